// ===== rtl/mir_pkg.sv =====
// types, constants and binomial table for multi_index_rank
`timescale 1ns / 1ps
package mir_pkg;

   localparam int NUM_INDICES = 8;
   localparam int DIGIT_BITS  = 4;
   localparam int MAX_TIER    = 15;

   localparam int KEY_BITS  = 32;
   localparam int LEN_W     = 4;
   localparam int CFG_W     = 4;
   localparam int RANK_W    = 20;
   localparam int TIER_W    = 7;
   localparam int CNT_W     = $clog2(NUM_INDICES + 1);
   localparam int TBL_ROWS  = MAX_TIER + NUM_INDICES;
   localparam int TBL_COLS  = NUM_INDICES + 1;
   localparam int ROW_W     = $clog2(TBL_ROWS);
   localparam int PAIRS     = (NUM_INDICES + 1) / 2;

   localparam logic [CFG_W-1:0] ACTIVE_COUNT_RESET = CFG_W'(NUM_INDICES);

   typedef struct packed {
      logic [KEY_BITS-1:0] key_digits;
      logic [LEN_W-1:0]    key_length;
   } req_payload_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [TIER_W-1:0] tier;
      logic              tier_over;
   } rsp_payload_type;

   // running digit sums and flags after the prefix stages
   typedef struct packed {
      logic [NUM_INDICES-1:0][TIER_W-1:0] run;
      logic [NUM_INDICES-1:0]             pos_on;
      logic                               len_nz;
      logic [TIER_W-1:0]                  tier;
      logic                               over;
   } pfx_stage_type;

   // binomial terms ready for the adder tree
   typedef struct packed {
      logic [NUM_INDICES-1:0][RANK_W-1:0] term;
      logic                               base;
      logic [TIER_W-1:0]                  tier;
      logic                               over;
   } term_stage_type;

   typedef logic [TBL_ROWS-1:0][TBL_COLS-1:0][RANK_W-1:0] binom_table_type;

   // pascal triangle, each entry wrapped to the rank width
   function automatic binom_table_type build_binom();
      binom_table_type tbl;
      tbl = '0;
      for (int n = 0; n < TBL_ROWS; n++) begin
         tbl[n][0] = RANK_W'(1);
         for (int k = 1; k < TBL_COLS; k++) begin
            if (n == 0) begin
               tbl[n][k] = '0;
            end else begin
               tbl[n][k] = tbl[n-1][k-1] + tbl[n-1][k];
            end
         end
      end
      return tbl;
   endfunction

   localparam binom_table_type BINOM_TABLE = build_binom();

endpackage

// ===== rtl/mir_prefix.sv =====
// input clamp stage and running digit sum stage
`timescale 1ns / 1ps
module mir_prefix import mir_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  req_payload_type   in_payload,
   input  logic [CFG_W-1:0]  active_count,
   output logic              out_valid,
   output pfx_stage_type     out_stage
);

   logic [NUM_INDICES-1:0][DIGIT_BITS-1:0] raw_digit;
   logic [CNT_W-1:0]                       a_eff;
   logic [CNT_W-1:0]                       len_eff;

   logic [NUM_INDICES-1:0][DIGIT_BITS-1:0] digit_in, digit_ff;
   logic [NUM_INDICES-1:0]                 pos_on_in, pos_on_ff;
   logic                                   len_nz_in, len_nz_ff;
   logic                                   s1_valid_ff;

   pfx_stage_type                          stage_in, stage_ff;
   logic                                   s2_valid_ff;

   // digits that lie past the key word read as zero
   for (genvar g = 0; g < NUM_INDICES; g++) begin : g_dig
      if ((g + 1) * DIGIT_BITS <= KEY_BITS) begin : g_in
         assign raw_digit[g] = in_payload.key_digits[g*DIGIT_BITS +: DIGIT_BITS];
      end else begin : g_out
         assign raw_digit[g] = '0;
      end
   end

   always_comb begin
      if (int'(active_count) > NUM_INDICES) begin
         a_eff = CNT_W'(NUM_INDICES);
      end else begin
         a_eff = CNT_W'(active_count);
      end
      if (int'(in_payload.key_length) > int'(a_eff)) begin
         len_eff = a_eff;
      end else begin
         len_eff = CNT_W'(in_payload.key_length);
      end
      for (int i = 0; i < NUM_INDICES; i++) begin
         digit_in[i]  = (i < int'(len_eff)) ? raw_digit[i] : '0;
         pos_on_in[i] = (i < int'(a_eff));
      end
      len_nz_in = (len_eff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         digit_ff  <= digit_in;
         pos_on_ff <= pos_on_in;
         len_nz_ff <= len_nz_in;
      end
   end

   // short chain of narrow adds
   always_comb begin
      stage_in        = '0;
      stage_in.run[0] = TIER_W'(digit_ff[0]);
      for (int i = 1; i < NUM_INDICES; i++) begin
         stage_in.run[i] = stage_in.run[i-1] + TIER_W'(digit_ff[i]);
      end
      stage_in.pos_on = pos_on_ff;
      stage_in.len_nz = len_nz_ff;
      stage_in.tier   = stage_in.run[NUM_INDICES-1];
      stage_in.over   = (int'(stage_in.run[NUM_INDICES-1]) > MAX_TIER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/mir_lookup.sv =====
// binomial table lookup stage
`timescale 1ns / 1ps
module mir_lookup import mir_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  pfx_stage_type   in_stage,
   output logic            out_valid,
   output term_stage_type  out_stage
);

   logic [NUM_INDICES-1:0][ROW_W-1:0] row;
   term_stage_type                    stage_in, stage_ff;
   logic                              valid_ff;

   // running sums stay within the table rows whenever the tier is in range
   always_comb begin
      stage_in = '0;
      for (int i = 0; i < NUM_INDICES; i++) begin
         row[i] = in_stage.run[i][ROW_W-1:0] + ROW_W'(i);
         if (in_stage.pos_on[i] && !in_stage.over) begin
            stage_in.term[i] = BINOM_TABLE[row[i]][i+1];
         end else begin
            stage_in.term[i] = '0;
         end
      end
      stage_in.base = in_stage.len_nz && !in_stage.over;
      stage_in.tier = in_stage.tier;
      stage_in.over = in_stage.over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/mir_accum.sv =====
// two-level registered adder tree that forms the rank
`timescale 1ns / 1ps
module mir_accum import mir_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  term_stage_type   in_stage,
   output logic             out_valid,
   output rsp_payload_type  out_payload
);

   logic [PAIRS-1:0][RANK_W-1:0] pair_in, pair_ff;
   logic                         base_ff;
   logic [TIER_W-1:0]            tier_ff;
   logic                         over_ff;
   logic                         s4_valid_ff;

   logic [RANK_W-1:0]            total;
   rsp_payload_type              rsp_in, rsp_ff;
   logic                         s5_valid_ff;

   always_comb begin
      for (int p = 0; p < PAIRS; p++) begin
         if (2*p + 1 < NUM_INDICES) begin
            pair_in[p] = in_stage.term[2*p] + in_stage.term[2*p+1];
         end else begin
            pair_in[p] = in_stage.term[2*p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
         base_ff <= in_stage.base;
         tier_ff <= in_stage.tier;
         over_ff <= in_stage.over;
      end
   end

   // wraps at the rank width
   always_comb begin
      total = RANK_W'(base_ff);
      for (int p = 0; p < PAIRS; p++) begin
         total = total + pair_ff[p];
      end
      rsp_in.rank      = total;
      rsp_in.tier      = tier_ff;
      rsp_in.tier_over = over_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid   = s5_valid_ff;
   assign out_payload = rsp_ff;

endmodule

// ===== rtl/multi_index_rank.sv =====
// an accepted req beat reaches its rsp beat through the clamp, sum, lookup, pair and rank registers
// throughput: one key per cycle unless an rsp beat is stalled; the five pipeline registers share one advance enable
// a stalled rsp beat holds every stage, req_ready follows rsp_ready through the last stage
// reset (synchronous, active high) empties the pipeline and sets active_count to 8
// the binomial table is a constant and needs no fill after reset
`timescale 1ns / 1ps
module multi_index_rank import mir_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_payload_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   logic [CFG_W-1:0] active_count_ff, active_count_in;
   logic             advance;
   logic             pfx_valid;
   pfx_stage_type    pfx_stage;
   logic             lut_valid;
   term_stage_type   lut_stage;

   assign active_count_in = csr_wr_en ? csr_wr_data : active_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= ACTIVE_COUNT_RESET;
      end else begin
         active_count_ff <= active_count_in;
      end
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   mir_prefix u_prefix (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_payload   (req_payload),
      .active_count (active_count_ff),
      .out_valid    (pfx_valid),
      .out_stage    (pfx_stage)
   );

   mir_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pfx_valid),
      .in_stage  (pfx_stage),
      .out_valid (lut_valid),
      .out_stage (lut_stage)
   );

   mir_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (lut_valid),
      .in_stage    (lut_stage),
      .out_valid   (rsp_valid),
      .out_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // an overflowing tier forces the rank to zero
   a_over_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.tier_over |-> rsp_payload.rank == '0)
      else $error("rank not zero on tier overflow");

   // flag agrees with the tier it reports
   a_over_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.tier_over == (int'(rsp_payload.tier) > MAX_TIER)))
      else $error("tier_over disagrees with tier");

   // an all-zero key only gets the base count
   a_zero_tier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.tier == '0 |-> rsp_payload.rank <= RANK_W'(1))
      else $error("rank too large for zero tier");

   // the pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp beat right after reset");
`endif

endmodule
